/* rtl/vec3_target_interpolator_unit_defines.svh */
// Assertion macros used by the checker of the interpolator.
`ifndef VEC3_TARGET_INTERPOLATOR_UNIT_DEFINES_SVH
`define VEC3_TARGET_INTERPOLATOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define V3TI_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define V3TI_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/v3ti_pkg.sv */
package v3ti_pkg;

  localparam int unsigned CW       = 32;  // Q16.16 coordinate
  localparam int unsigned DTW      = 16;
  localparam int unsigned OPW      = 2;
  localparam int unsigned MODEW    = 2;
  localparam int unsigned CFG_IDXW = 2;
  localparam int unsigned NUMW     = 64;  // divider dividend / sqrt radicand
  localparam int unsigned DENW     = 33;  // divider divisor

  localparam logic [OPW-1:0] OP_TICK       = 2'd0;
  localparam logic [OPW-1:0] OP_SET_TARGET = 2'd1;
  localparam logic [OPW-1:0] OP_SET_POS    = 2'd2;

  localparam logic [MODEW-1:0] MODE_LINEAR   = 2'd0;
  localparam logic [MODEW-1:0] MODE_SMOOTH   = 2'd1;
  localparam logic [MODEW-1:0] MODE_DURATION = 2'd2;

  localparam logic [CFG_IDXW-1:0] CFG_MODE   = 2'd0;
  localparam logic [CFG_IDXW-1:0] CFG_STEP   = 2'd1;
  localparam logic [CFG_IDXW-1:0] CFG_SMOOTH = 2'd2;

  localparam logic [CW-1:0] STEP_RESET = 32'h0001_0000;

  typedef struct packed {
    logic start;
    logic is_sqrt;
  } unit_req_t;

endpackage

/* rtl/vec3_target_interpolator_unit.sv */
// Moves a current 3D point (signed Q16.16) toward a target. Each accepted item gives
// exactly one result item with the state after it. Set-target, set-position, unused
// operations, ticks in the unused mode and zero-duration ticks go straight to the
// output. A duration tick works out the elapsed fraction, with a divide when it needs
// one, then lerps each axis. A step tick first finds the distance (six squares, then
// one square root) and goes to the result when the step covers the rest of the way;
// otherwise one divide per axis follows. Smooth mode adds a divide while the point is
// inside the smoothing distance. The work runs on the one bit-serial divide/sqrt unit
// and the one shared 32x32 multiplier; a stalled output holds the sequencer in its
// output state. The block takes one item at a time: in_ready_o is high only while the
// sequencer is idle, and a new item may enter while the last result still waits on the
// output.
module vec3_target_interpolator_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [v3ti_pkg::CFG_IDXW-1:0]     cfg_idx_i,
  input  logic [v3ti_pkg::CW-1:0]           cfg_wdata_i,
  // input items
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [v3ti_pkg::OPW-1:0]          operation_i,
  input  logic signed [v3ti_pkg::CW-1:0]    vec_x_i,
  input  logic signed [v3ti_pkg::CW-1:0]    vec_y_i,
  input  logic signed [v3ti_pkg::CW-1:0]    vec_z_i,
  input  logic [v3ti_pkg::DTW-1:0]          delta_time_i,
  input  logic [v3ti_pkg::CW-1:0]           now_ms_i,
  // result items
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [v3ti_pkg::CW-1:0]    cur_x_o,
  output logic signed [v3ti_pkg::CW-1:0]    cur_y_o,
  output logic signed [v3ti_pkg::CW-1:0]    cur_z_o,
  output logic signed [v3ti_pkg::CW-1:0]    goal_x_o,
  output logic signed [v3ti_pkg::CW-1:0]    goal_y_o,
  output logic signed [v3ti_pkg::CW-1:0]    goal_z_o,
  output logic                              arrived_o
);
  import v3ti_pkg::*;

  // sequencer states
  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_DIFF  = 5'd1;   // per-axis |d| and sign
  localparam logic [4:0] ST_MSTEP = 5'd2;   // dt * speed
  localparam logic [4:0] ST_STEP  = 5'd3;
  localparam logic [4:0] ST_SQM   = 5'd4;   // square terms
  localparam logic [4:0] ST_SQA   = 5'd5;
  localparam logic [4:0] ST_SQRT  = 5'd6;
  localparam logic [4:0] ST_SQW   = 5'd7;
  localparam logic [4:0] ST_SMM   = 5'd8;   // smooth: step * dist / smooth
  localparam logic [4:0] ST_SMD   = 5'd9;
  localparam logic [4:0] ST_SMW   = 5'd10;
  localparam logic [4:0] ST_CMP   = 5'd11;
  localparam logic [4:0] ST_MVM   = 5'd12;  // per-axis |d| * step / dist
  localparam logic [4:0] ST_MVD   = 5'd13;
  localparam logic [4:0] ST_MVW   = 5'd14;
  localparam logic [4:0] ST_TIME  = 5'd15;  // duration: elapsed fraction
  localparam logic [4:0] ST_TDW   = 5'd16;
  localparam logic [4:0] ST_LRM   = 5'd17;  // per-axis lerp
  localparam logic [4:0] ST_LRA   = 5'd18;
  localparam logic [4:0] ST_OUT   = 5'd19;

  localparam logic [2:0] LAST_AXIS = 3'd2;
  localparam logic [2:0] LAST_SQ   = 3'd5;  // three exact squares, then three halved
  localparam int unsigned TW = DTW + 1;      // t in Q1.16, 1.0 included
  localparam logic [TW-1:0] T_ONE = TW'(1) << DTW;

  logic [4:0]        state_q;
  logic [MODEW-1:0]  mode_q;
  logic [CW-1:0]     sod_q, smooth_q;

  logic [CW-1:0]     cur_q [3];
  logic [CW-1:0]     org_q [3];
  logic [CW-1:0]     tgt_q [3];
  logic [CW-1:0]     start_q;

  logic [DTW-1:0]    dt_q;
  logic [CW-1:0]     now_q;
  logic [CW-1:0]     mag_q [3];
  logic              neg_q [3];
  logic [2:0]        idx_q;
  logic [CW-1:0]     step_q;
  logic [CW:0]       dist_q;
  logic [NUMW+1:0]   ssum_q;  // exact sum of squares, may pass 64 bits
  logic [NUMW-1:0]   hsum_q;  // sum of halved squares for the huge case
  logic [NUMW-1:0]   prod_q;
  logic [TW-1:0]     t_q;

  logic              out_valid_q;
  logic [CW-1:0]     o_cur_q [3];
  logic [CW-1:0]     o_tgt_q [3];
  logic              o_arr_q;

  // shared multiplier
  logic [CW-1:0]     mul_a, mul_b;
  logic [NUMW-1:0]   mul_p;
  logic [1:0]        ax;
  logic [1:0]        sq_ax;

  // divide/sqrt unit
  unit_req_t         u_req;
  logic [NUMW-1:0]   u_num, u_res;
  logic [DENW-1:0]   u_den;
  logic              u_done;

  logic [CW:0]       diff [3];
  logic [CW-1:0]     elapsed;
  logic [CW:0]       dist_new;
  logic              huge;
  logic [CW-1:0]     mv;
  logic [CW-1:0]     lerp_mv;

  assign ax      = idx_q[1:0];
  assign sq_ax   = (idx_q < 3'd3) ? idx_q[1:0] : 2'(idx_q - 3'd3);
  assign elapsed = now_q - start_q;
  assign huge    = ssum_q[NUMW+1:NUMW] != 2'b00;
  assign dist_new = huge ? {u_res[CW-1:0], 1'b0} : {1'b0, u_res[CW-1:0]};
  assign mv      = u_res[CW-1:0];
  assign lerp_mv = prod_q[CW+DTW-1:DTW];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (mode_q == MODE_DURATION) begin
        diff[i] = {tgt_q[i][CW-1], tgt_q[i]} - {org_q[i][CW-1], org_q[i]};
      end else begin
        diff[i] = {tgt_q[i][CW-1], tgt_q[i]} - {cur_q[i][CW-1], cur_q[i]};
      end
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_MSTEP: begin
        mul_a = {{(CW-DTW){1'b0}}, dt_q};
        mul_b = sod_q;
      end
      ST_SQM: begin
        mul_a = (idx_q < 3'd3) ? mag_q[sq_ax] : (mag_q[sq_ax] >> 1);
        mul_b = mul_a;
      end
      ST_SMM: begin
        mul_a = step_q;
        mul_b = dist_q[CW-1:0];
      end
      ST_MVM: begin
        mul_a = mag_q[ax];
        mul_b = step_q;
      end
      ST_LRM: begin
        mul_a = mag_q[ax];
        mul_b = {{(CW-TW){1'b0}}, t_q};
      end
      default: ;
    endcase
    mul_p = mul_a * mul_b;
  end

  always_comb begin
    u_req = '0;
    u_num = prod_q;
    u_den = {1'b0, smooth_q};
    unique case (state_q)
      ST_SQRT: begin
        u_req.start   = 1'b1;
        u_req.is_sqrt = 1'b1;
        u_num = huge ? hsum_q : ssum_q[NUMW-1:0];
      end
      ST_SMD: u_req.start = 1'b1;
      ST_MVD: begin
        u_req.start = 1'b1;
        u_den = dist_q;
      end
      ST_TIME: begin
        // divide only when now is not before the start and the elapsed fraction is below 1
        u_req.start = (now_q >= start_q) &&
                      ({elapsed, {DTW{1'b0}}} < {{DTW{1'b0}}, sod_q});
        u_num = {elapsed, {CW{1'b0}}};
        u_den = {1'b0, sod_q};
      end
      default: ;
    endcase
  end

  v3ti_divsqrt u_divsqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (u_req),
    .num_i  (u_num),
    .den_i  (u_den),
    .res_o  (u_res),
    .done_o (u_done)
  );

  // configuration, state and sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_LINEAR;
      sod_q       <= STEP_RESET;
      smooth_q    <= '0;
      start_q     <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      for (int i = 0; i < 3; i++) begin
        cur_q[i] <= '0;
        org_q[i] <= '0;
        tgt_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MODE:   mode_q   <= cfg_wdata_i[MODEW-1:0];
          CFG_STEP:   sod_q    <= cfg_wdata_i;
          CFG_SMOOTH: smooth_q <= cfg_wdata_i;
          default: ;
        endcase
      end

      // a new result loads when the register is free or drains this cycle
      if (state_q == ST_OUT && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            case (operation_i)
              OP_TICK: begin
                case (mode_q) inside
                  MODE_LINEAR, MODE_SMOOTH: state_q <= ST_DIFF;
                  MODE_DURATION: begin
                    if (sod_q == '0) begin
                      for (int i = 0; i < 3; i++) cur_q[i] <= tgt_q[i];
                      state_q <= ST_OUT;
                    end else begin
                      state_q <= ST_DIFF;
                    end
                  end
                  default: state_q <= ST_OUT;  // unused mode: no change
                endcase
              end
              OP_SET_TARGET: begin
                for (int i = 0; i < 3; i++) org_q[i] <= cur_q[i];
                tgt_q[0] <= vec_x_i;
                tgt_q[1] <= vec_y_i;
                tgt_q[2] <= vec_z_i;
                start_q  <= now_ms_i;
                state_q  <= ST_OUT;
              end
              OP_SET_POS: begin
                cur_q[0] <= vec_x_i;
                cur_q[1] <= vec_y_i;
                cur_q[2] <= vec_z_i;
                org_q[0] <= vec_x_i;
                org_q[1] <= vec_y_i;
                org_q[2] <= vec_z_i;
                tgt_q[0] <= vec_x_i;
                tgt_q[1] <= vec_y_i;
                tgt_q[2] <= vec_z_i;
                state_q  <= ST_OUT;
              end
              default: state_q <= ST_OUT;
            endcase
          end
        end
        ST_DIFF: begin
          idx_q   <= '0;
          state_q <= (mode_q == MODE_DURATION) ? ST_TIME : ST_MSTEP;
        end
        ST_MSTEP: state_q <= ST_STEP;
        ST_STEP:  state_q <= ST_SQM;
        ST_SQM:   state_q <= ST_SQA;
        ST_SQA: begin
          idx_q   <= (idx_q == LAST_SQ) ? 3'd0 : idx_q + 3'd1;
          state_q <= (idx_q == LAST_SQ) ? ST_SQRT : ST_SQM;
        end
        ST_SQRT: state_q <= ST_SQW;
        ST_SQW: begin
          if (u_done) begin
            if ((mode_q == MODE_SMOOTH) && (dist_new < {1'b0, smooth_q})) begin
              state_q <= ST_SMM;
            end else begin
              state_q <= ST_CMP;
            end
          end
        end
        ST_SMM: state_q <= ST_SMD;
        ST_SMD: state_q <= ST_SMW;
        ST_SMW: if (u_done) state_q <= ST_CMP;
        ST_CMP: begin
          idx_q <= '0;
          if ({1'b0, step_q} >= dist_q) begin
            for (int i = 0; i < 3; i++) cur_q[i] <= tgt_q[i];
            state_q <= ST_OUT;
          end else begin
            state_q <= ST_MVM;
          end
        end
        ST_MVM: state_q <= ST_MVD;
        ST_MVD: state_q <= ST_MVW;
        ST_MVW: begin
          if (u_done) begin
            cur_q[ax] <= neg_q[ax] ? (cur_q[ax] - mv) : (cur_q[ax] + mv);
            idx_q     <= idx_q + 3'd1;
            state_q   <= (idx_q == LAST_AXIS) ? ST_OUT : ST_MVM;
          end
        end
        ST_TIME: state_q <= u_req.start ? ST_TDW : ST_LRM;
        ST_TDW:  if (u_done) state_q <= ST_LRM;
        ST_LRM:  state_q <= ST_LRA;
        ST_LRA: begin
          cur_q[ax] <= neg_q[ax] ? (org_q[ax] - lerp_mv) : (org_q[ax] + lerp_mv);
          idx_q     <= idx_q + 3'd1;
          state_q   <= (idx_q == LAST_AXIS) ? ST_OUT : ST_LRM;
        end
        ST_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      dt_q  <= delta_time_i;
      now_q <= now_ms_i;
    end
    case (state_q) inside
      ST_DIFF: begin
        for (int i = 0; i < 3; i++) begin
          neg_q[i] <= diff[i][CW];
          mag_q[i] <= diff[i][CW] ? 32'(-diff[i]) : diff[i][CW-1:0];
        end
        ssum_q <= '0;
        hsum_q <= '0;
      end
      ST_MSTEP, ST_SQM, ST_SMM, ST_MVM, ST_LRM: prod_q <= mul_p;
      ST_STEP: step_q <= prod_q[CW+DTW-1:DTW];
      ST_SQA: begin
        if (idx_q < 3'd3) ssum_q <= ssum_q + {2'b00, prod_q};
        else              hsum_q <= hsum_q + prod_q;
      end
      ST_SQW: if (u_done) dist_q <= dist_new;
      ST_SMW: if (u_done) step_q <= u_res[CW-1:0];
      ST_TIME: begin
        if (now_q < start_q) begin
          t_q <= '0;
        end else begin
          t_q <= T_ONE;  // replaced by the quotient when a divide runs
        end
      end
      ST_TDW: if (u_done) t_q <= u_res[TW-1:0];
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          for (int i = 0; i < 3; i++) begin
            o_cur_q[i] <= cur_q[i];
            o_tgt_q[i] <= tgt_q[i];
          end
          o_arr_q <= (cur_q[0] == tgt_q[0]) && (cur_q[1] == tgt_q[1]) &&
                     (cur_q[2] == tgt_q[2]);
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign cur_x_o     = o_cur_q[0];
  assign cur_y_o     = o_cur_q[1];
  assign cur_z_o     = o_cur_q[2];
  assign goal_x_o    = o_tgt_q[0];
  assign goal_y_o    = o_tgt_q[1];
  assign goal_z_o    = o_tgt_q[2];
  assign arrived_o   = o_arr_q;

endmodule

/* rtl/v3ti_divsqrt.sv */
// Bit-serial unit: restoring divide (one quotient bit per cycle) or
// integer square root (one root bit per cycle). done_o pulses when res_o is final.
module v3ti_divsqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  v3ti_pkg::unit_req_t           req_i,
  input  logic [v3ti_pkg::NUMW-1:0]     num_i,
  input  logic [v3ti_pkg::DENW-1:0]     den_i,
  output logic [v3ti_pkg::NUMW-1:0]     res_o,
  output logic                          done_o
);
  import v3ti_pkg::*;

  localparam int unsigned CNTW      = $clog2(NUMW + 1);
  localparam int unsigned SQRT_ITER = NUMW / 2;

  logic            busy_q, sqrt_q, done_q;
  logic [CNTW-1:0] cnt_q;
  logic [NUMW-1:0] acc_q;   // dividend/quotient shifter, or sqrt remainder
  logic [NUMW-1:0] root_q, bit_q;
  logic [DENW-1:0] rem_q, den_q;

  logic [DENW:0]   rem_sh, rem_sub;
  logic            div_ge;
  logic [NUMW-1:0] trial;
  logic            sq_ge;

  always_comb begin
    rem_sh  = {rem_q, acc_q[NUMW-1]};
    div_ge  = rem_sh >= {1'b0, den_q};
    rem_sub = rem_sh - {1'b0, den_q};
    trial   = root_q + bit_q;
    sq_ge   = acc_q >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !req_i.start && busy_q && (cnt_q == CNTW'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.is_sqrt ? CNTW'(SQRT_ITER) : CNTW'(NUMW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      sqrt_q <= req_i.is_sqrt;
      acc_q  <= num_i;
      rem_q  <= '0;
      den_q  <= den_i;
      root_q <= '0;
      bit_q  <= NUMW'(1) << (NUMW - 2);
    end else if (busy_q) begin
      if (sqrt_q) begin
        if (sq_ge) begin
          acc_q  <= acc_q - trial;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end else begin
        acc_q <= {acc_q[NUMW-2:0], div_ge};
        rem_q <= div_ge ? rem_sub[DENW-1:0] : rem_sh[DENW-1:0];
      end
    end
  end

  assign res_o  = sqrt_q ? root_q : acc_q;
  assign done_o = done_q;

endmodule

/* rtl/v3ti_checker.sv */
`include "vec3_target_interpolator_unit_defines.svh"

module v3ti_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              cfg_we_i,
  input logic [v3ti_pkg::CFG_IDXW-1:0]     cfg_idx_i,
  input logic [v3ti_pkg::CW-1:0]           cfg_wdata_i,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic [v3ti_pkg::OPW-1:0]          operation_i,
  input logic signed [v3ti_pkg::CW-1:0]    vec_x_i,
  input logic signed [v3ti_pkg::CW-1:0]    vec_y_i,
  input logic signed [v3ti_pkg::CW-1:0]    vec_z_i,
  input logic [v3ti_pkg::DTW-1:0]          delta_time_i,
  input logic [v3ti_pkg::CW-1:0]           now_ms_i,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic signed [v3ti_pkg::CW-1:0]    cur_x_o,
  input logic signed [v3ti_pkg::CW-1:0]    cur_y_o,
  input logic signed [v3ti_pkg::CW-1:0]    cur_z_o,
  input logic signed [v3ti_pkg::CW-1:0]    goal_x_o,
  input logic signed [v3ti_pkg::CW-1:0]    goal_y_o,
  input logic signed [v3ti_pkg::CW-1:0]    goal_z_o,
  input logic                              arrived_o
);

  // a stalled result item stays valid and holds cur_x, goal_z and arrived
  `V3TI_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(cur_x_o) && $stable(goal_z_o) && $stable(arrived_o), "stalled result changed")

  // in_ready_o is low in the cycle after an item is accepted
  `V3TI_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "ready right after accept")

  // arrived flag agrees with the reported points
  `V3TI_ASSERT_IMP(a_arrived_match, out_valid_o, arrived_o == ((cur_x_o == goal_x_o) && (cur_y_o == goal_y_o) && (cur_z_o == goal_z_o)), "arrived flag mismatch")

endmodule

bind vec3_target_interpolator_unit v3ti_checker u_v3ti_checker (.*);

/* dv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import v3ti_pkg::*;

  // Codes the package leaves out: the spare operation and the spare mode.
  localparam logic [OPW-1:0]   OP_UNUSED   = 2'd3;
  localparam logic [MODEW-1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned      STALL_LIMIT = 5000;

  typedef struct {
    logic [OPW-1:0] op;
    logic [CW-1:0]  vx, vy, vz;
    logic [DTW-1:0] dt;
    logic [CW-1:0]  now;
  } cmd_item_t;

  typedef struct {
    logic [CW-1:0] cx, cy, cz, gx, gy, gz;
    logic          hit;
  } point_report_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDXW-1:0] cfg_idx_i = '0;
  logic [CW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [OPW-1:0] operation_i = '0;
  logic signed [CW-1:0] vec_x_i = '0, vec_y_i = '0, vec_z_i = '0;
  logic [DTW-1:0] delta_time_i = '0;
  logic [CW-1:0] now_ms_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [CW-1:0] cur_x_o, cur_y_o, cur_z_o, goal_x_o, goal_y_o, goal_z_o;
  logic arrived_o;

  always #5 clk_i = ~clk_i;

  vec3_target_interpolator_unit dut (.*);

  // Mirror of the block's registers and point state.
  logic [MODEW-1:0] mirror_mode = MODE_LINEAR;
  logic [CW-1:0]    mirror_speed = STEP_RESET;
  logic [CW-1:0]    mirror_smooth = '0;
  int               pos_now[3] = '{0, 0, 0};
  int               pos_origin[3] = '{0, 0, 0};
  int               pos_goal[3] = '{0, 0, 0};
  logic [CW-1:0]    t_start = '0;

  cmd_item_t     cmd_queue[$];
  point_report_t report_queue[$];
  int            errors = 0;
  int            n_sent = 0, n_checked = 0, n_arrived = 0;
  bit            calm = 1'b0;   // no idling in the closing stretch

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] abs_diff(input int a, input int b);
    longint d;
    d = longint'(a) - longint'(b);
    return d < 0 ? 64'(-d) : 64'(d);
  endfunction

  // Euclidean distance from the current point to the goal, Q16.16 raw units.
  function automatic logic [63:0] goal_distance();
    logic [63:0] s, q, m;
    bit over;
    over = 1'b0;
    s = '0;
    for (int i = 0; i < 3; i++) begin
      m = abs_diff(pos_goal[i], pos_now[i]);
      q = m * m;
      if (s + q < s) over = 1'b1;
      s = s + q;
    end
    if (!over) return int_sqrt(s);
    // sum overflowed: halve the axes and double the root
    s = '0;
    for (int i = 0; i < 3; i++) begin
      m = abs_diff(pos_goal[i], pos_now[i]) >> 1;
      s = s + m * m;
    end
    return 2 * int_sqrt(s);
  endfunction

  function automatic void advance_by_step(input logic [DTW-1:0] dt);
    logic [63:0] step, span, mv;
    longint d;
    step = (64'(dt) * 64'(mirror_speed)) >> 16;
    span = goal_distance();
    if (mirror_mode == MODE_SMOOTH && span < 64'(mirror_smooth))
      step = (step * span) / 64'(mirror_smooth);
    if (step >= span) begin
      pos_now = pos_goal;
      return;
    end
    for (int i = 0; i < 3; i++) begin
      d = longint'(pos_goal[i]) - longint'(pos_now[i]);
      mv = (abs_diff(pos_goal[i], pos_now[i]) * step) / span;
      pos_now[i] = int'(longint'(pos_now[i]) + (d < 0 ? -longint'(mv) : longint'(mv)));
    end
  endfunction

  function automatic void advance_by_time(input logic [CW-1:0] now);
    logic [63:0] frac, e, mv;
    longint d;
    if (mirror_speed == 0) begin
      pos_now = pos_goal;
      return;
    end
    if (now < t_start) begin
      frac = '0;
    end else begin
      e = 64'(now - t_start);
      if ((e << 16) >= 64'(mirror_speed)) frac = 64'd65536;
      else frac = (e << 32) / 64'(mirror_speed);
    end
    for (int i = 0; i < 3; i++) begin
      d = longint'(pos_goal[i]) - longint'(pos_origin[i]);
      mv = (abs_diff(pos_goal[i], pos_origin[i]) * frac) >> 16;
      pos_now[i] = int'(longint'(pos_origin[i]) + (d < 0 ? -longint'(mv) : longint'(mv)));
    end
  endfunction

  // Applies one item to the mirror and returns the report the block must give.
  function automatic point_report_t apply_item(input cmd_item_t it);
    point_report_t r;
    int v[3];
    v = '{int'(it.vx), int'(it.vy), int'(it.vz)};
    case (it.op)
      OP_TICK: begin
        if (mirror_mode == MODE_LINEAR || mirror_mode == MODE_SMOOTH) advance_by_step(it.dt);
        else if (mirror_mode == MODE_DURATION) advance_by_time(it.now);
      end
      OP_SET_TARGET: begin
        pos_origin = pos_now;
        pos_goal = v;
        t_start = it.now;
      end
      OP_SET_POS: begin
        pos_now = v;
        pos_origin = v;
        pos_goal = v;
      end
      default: ;
    endcase
    r.cx = pos_now[0];  r.cy = pos_now[1];  r.cz = pos_now[2];
    r.gx = pos_goal[0]; r.gy = pos_goal[1]; r.gz = pos_goal[2];
    r.hit = (pos_now == pos_goal);
    return r;
  endfunction

  // Input side: presents queued items, with random idle bursts between them.
  int in_gap = 0;
  always @(posedge clk_i) begin
    cmd_item_t it;
    logic nv;
    nv = in_valid_i;
    if (in_valid_i && in_ready_o) begin
      it = cmd_queue.pop_front();
      report_queue.push_back(apply_item(it));
      n_sent++;
      nv = 1'b0;
    end
    if (!nv && rst_ni) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (cmd_queue.size() != 0) begin
        if (!calm && $urandom_range(0, 5) == 0) begin
          in_gap = $urandom_range(1, 17) - 1;
        end else begin
          it = cmd_queue[0];
          operation_i <= it.op;
          vec_x_i <= it.vx;
          vec_y_i <= it.vy;
          vec_z_i <= it.vz;
          delta_time_i <= it.dt;
          now_ms_i <= it.now;
          nv = 1'b1;
        end
      end
    end
    in_valid_i <= nv;
  end

  // Output side: random stall bursts, compares each result with the oldest prediction.
  int out_gap = 0;
  always @(posedge clk_i) begin
    point_report_t want;
    if (out_valid_o && out_ready_i) begin
      if (report_queue.size() == 0) begin
        $display("%0t: result with nothing predicted", $time);
        errors++;
      end else begin
        want = report_queue.pop_front();
        if (cur_x_o !== want.cx || cur_y_o !== want.cy || cur_z_o !== want.cz ||
            goal_x_o !== want.gx || goal_y_o !== want.gy || goal_z_o !== want.gz ||
            arrived_o !== want.hit) begin
          $display("%0t: expected cur %h %h %h goal %h %h %h arrived %b", $time,
                   want.cx, want.cy, want.cz, want.gx, want.gy, want.gz, want.hit);
          $display("%0t:   actual cur %h %h %h goal %h %h %h arrived %b", $time,
                   cur_x_o, cur_y_o, cur_z_o, goal_x_o, goal_y_o, goal_z_o, arrived_o);
          errors++;
        end
        if (want.hit) n_arrived++;
      end
      n_checked++;
    end
    if (out_gap > 0) begin
      out_gap--;
      out_ready_i <= 1'b0;
    end else if (!calm && rst_ni && $urandom_range(0, 5) == 0) begin
      out_gap = $urandom_range(1, 17) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= rst_ni;
    end
  end

  // Watchdog on handshake progress.
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("vec3_target_interpolator_unit: mismatch");
      $finish;
    end
  end

  task automatic wait_drained();
    while (cmd_queue.size() != 0 || report_queue.size() != 0 || in_valid_i)
      @(posedge clk_i);
  endtask

  // Register write, only ever issued with the block idle.
  task automatic write_reg(input logic [CFG_IDXW-1:0] idx, input logic [CW-1:0] val);
    wait_drained();
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_MODE:   mirror_mode = val[MODEW-1:0];
      CFG_STEP:   mirror_speed = val;
      CFG_SMOOTH: mirror_smooth = val;
      default: ;
    endcase
  endtask

  task automatic queue_item(input logic [OPW-1:0] op, input logic [CW-1:0] x, y, z,
                            input logic [DTW-1:0] dt, input logic [CW-1:0] now);
    cmd_item_t it;
    it.op = op; it.vx = x; it.vy = y; it.vz = z; it.dt = dt; it.now = now;
    cmd_queue.push_back(it);
  endtask

  // Mostly nearby points, sometimes full range or the rails.
  function automatic logic [CW-1:0] pick_coord();
    case ($urandom_range(0, 9)) inside
      0: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      1, 2: return $urandom;
      default: return 32'($signed($urandom_range(0, 400 << 16)) - (200 << 16));
    endcase
  endfunction

  function automatic logic [CW-1:0] pick_speed();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hffff_ffff;
      2: return $urandom;
      default: return $urandom_range(1, 2000) << 16;
    endcase
  endfunction

  logic [CW-1:0] app_ms = 32'd1000;

  initial begin
    int ticks;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: rails, the huge-distance path, both tick lengths, spare operation.
    queue_item(OP_SET_POS, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0);
    queue_item(OP_TICK, 0, 0, 0, 16'hffff, 0);
    queue_item(OP_SET_POS, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0);
    queue_item(OP_SET_TARGET, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 32'hffff_ffff);
    queue_item(OP_TICK, 0, 0, 0, 16'hffff, 0);
    queue_item(OP_TICK, 0, 0, 0, 16'h0000, 0);
    queue_item(OP_UNUSED, 32'h1234_5678, 32'hffff_ffff, 32'h8000_0001, 16'hffff, 32'hffff_ffff);
    queue_item(OP_SET_TARGET, 32'h0003_0000, 32'hfffc_0000, 32'h0000_0000, 0, 0);
    queue_item(OP_TICK, 0, 0, 0, 16'h8000, 0);
    write_reg(CFG_MODE, MODE_UNUSED);
    queue_item(OP_TICK, 0, 0, 0, 16'hffff, 0);
    // Duration mode: zero duration jumps, then before-start, mid-way and past the end.
    write_reg(CFG_MODE, MODE_DURATION);
    write_reg(CFG_STEP, 32'h0);
    queue_item(OP_TICK, 0, 0, 0, 0, 0);
    write_reg(CFG_STEP, 32'd1000 << 16);
    queue_item(OP_SET_TARGET, 32'h0064_0000, 32'hff9c_0000, 32'h0001_0000, 0, 5000);
    queue_item(OP_TICK, 0, 0, 0, 0, 4000);
    queue_item(OP_TICK, 0, 0, 0, 0, 5500);
    queue_item(OP_TICK, 0, 0, 0, 0, 7000);
    // Smooth mode, slowing inside a large smoothing radius.
    write_reg(CFG_MODE, MODE_SMOOTH);
    write_reg(CFG_STEP, 32'd50 << 16);
    write_reg(CFG_SMOOTH, 32'd500 << 16);
    queue_item(OP_SET_TARGET, 32'h00c8_0000, 32'h0, 32'h0, 0, 0);
    repeat (4) queue_item(OP_TICK, 0, 0, 0, 16'hffff, 0);

    // Random phases: new settings each time, then target runs with random ticks.
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(CFG_MODE, (ph % 5 == 4) ? MODE_UNUSED : MODEW'($urandom_range(0, 2)));
      write_reg(CFG_STEP, pick_speed());
      write_reg(CFG_SMOOTH, ($urandom_range(0, 3) == 0) ? 32'hffff_ffff
                            : ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom_range(0, 600 << 16));
      for (int n = 0; n < 54; n++) begin
        case ($urandom_range(0, 9)) inside
          0: queue_item(OP_SET_POS, pick_coord(), pick_coord(), pick_coord(),
                        $urandom, $urandom);
          1: queue_item(OP_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom);
          2, 3: begin
            app_ms = $urandom_range(0, 9) == 0 ? $urandom : app_ms + $urandom_range(0, 300);
            queue_item(OP_SET_TARGET, pick_coord(), pick_coord(), pick_coord(),
                       $urandom, app_ms);
          end
          default: begin
            app_ms = $urandom_range(0, 15) == 0 ? $urandom : app_ms + $urandom_range(0, 400);
            queue_item(OP_TICK, $urandom, $urandom, $urandom, $urandom, app_ms);
          end
        endcase
      end
      if (ph == 10) calm = 1'b1;
    end

    wait_drained();
    repeat (400) @(posedge clk_i);
    $display("%0d items sent, %0d results checked (%0d at the target), 12 random settings",
             n_sent, n_checked, n_arrived);
    $display("covered linear, smooth, duration and unused modes with idle and stall bursts");
    if (errors == 0 && report_queue.size() == 0) begin
      $display("vec3_target_interpolator_unit: match");
    end else begin
      $display("vec3_target_interpolator_unit: mismatch");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/v3ti_pkg.sv
rtl/v3ti_divsqrt.sv
rtl/vec3_target_interpolator_unit.sv
rtl/v3ti_checker.sv
dv/tb_top.sv
